// ===== rtl/core/maf_pkg.sv =====
// Shared types and constants for the moving average filter.
// Used by the serial divider and the top level; depends on nothing.
package maf_pkg;

  // Width and reset value of the window length register.
  localparam int WINDOW_BITS  = 7;
  localparam int WINDOW_RESET = 8;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } maf_div_status_t;

endpackage

// ===== rtl/core/maf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the sample store of the moving average filter; no dependencies.
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/maf_div.sv =====
// Restoring serial divider: signed dividend by unsigned divisor, one quotient
// bit per cycle, quotient truncated toward zero. Depends on maf_pkg.
module maf_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [NUM_W-1:0] quot,
  output maf_pkg::maf_div_status_t status
);
  import maf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] rem;
  logic             neg;

  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try the divisor.
  assign trial = {rem, dvd[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register fills with quotient bits from the bottom as it shifts.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NUM_W-1];
      dvd <= num[NUM_W-1] ? (~num + 1'b1) : num;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      dvd <= {dvd[NUM_W-2:0], fits};
    end
  end

  assign quot        = neg ? -$signed(dvd) : $signed(dvd);
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/core/moving_average_filter_unit.sv =====
// Boxcar moving average with a running sum and a circular sample store.
// Steps: a word is accepted in S_IDLE, the oldest sample is taken off the sum in
// S_SUB once the window is full, the new one is added in S_ADD, and from S_START
// on the serial divider divides the sum by the fill count, one quotient bit per cycle.
// A new word is taken only once the previous division is done; a mean
// still waiting at the output holds the next division back until it is taken.
// Reset: synchronous; window length returns to 8 and the history is cleared.
module moving_average_filter_unit #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     mean,
  input  logic                              window_length_we,
  input  logic [maf_pkg::WINDOW_BITS-1:0]   window_length
);
  import maf_pkg::*;

  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int WIN_RESET = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUB   = 5'b00010,
    S_ADD   = 5'b00100,
    S_START = 5'b01000,
    S_DIV   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]              win;
  logic [CNT_W-1:0]              win_eff;
  logic [POS_W-1:0]              pos;
  logic [CNT_W-1:0]              count;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          result_held;

  logic                          full;
  logic [CNT_W-1:0]              pos_inc;
  logic [SAMPLE_BITS-1:0]        old_sample;
  logic signed [SUM_W-1:0]       old_ext;
  logic signed [SUM_W-1:0]       new_ext;
  logic                          in_fire;
  logic                          load_out;
  logic                          div_start;
  logic signed [SUM_W-1:0]       div_quot;
  maf_div_status_t               div_stat;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = count >= win;
  assign pos_inc   = CNT_W'(pos) + CNT_W'(1);
  assign old_ext   = {{(SUM_W - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
  assign new_ext   = {{(SUM_W - SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  // The divider is only restarted once its previous quotient has left for the output.
  assign div_start = (state == S_START) && !result_held;
  // The quotient moves to the output register once that register is free.
  assign load_out  = result_held && (!out_valid || out_ready);

  // A zero window acts as one, and anything above the store depth is clamped.
  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_length);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_SUB;
      S_SUB:   state_next = S_ADD;
      S_ADD:   state_next = S_START;
      S_START: if (!result_held) state_next = S_DIV;
      S_DIV:   if (div_stat.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win         <= CNT_W'(WIN_RESET);
      pos         <= '0;
      count       <= '0;
      sum         <= '0;
      out_valid   <= 1'b0;
      result_held <= 1'b0;
    end else begin
      state <= state_next;
      if (window_length_we) begin
        win   <= win_eff;
        pos   <= '0;
        count <= '0;
        sum   <= '0;
      end else if (state == S_SUB) begin
        if (full) begin
          sum <= sum - old_ext;
        end
      end else if (state == S_ADD) begin
        sum   <= sum + new_ext;
        count <= full ? win : count + CNT_W'(1);
        pos   <= (pos_inc >= win) ? '0 : pos_inc[POS_W-1:0];
      end

      if (state == S_DIV && div_stat.done) begin
        result_held <= 1'b1;
      end else if (load_out) begin
        result_held <= 1'b0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The divider holds its quotient until the next start, so the output register
  // can pick it up late while the next word is already being taken.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= sample;
    end
    if (load_out) begin
      mean <= div_quot[SAMPLE_BITS-1:0];
    end
  end

  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (state == S_ADD),
    .waddr (pos),
    .wdata (sample_r),
    .re    (in_fire),
    .raddr (pos),
    .rdata (old_sample)
  );

  maf_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (sum),
    .den    (count),
    .quot   (div_quot),
    .status (div_stat)
  );

  // A new division must never start while the previous one still runs, and it
  // must never start while the previous quotient has not yet reached the output.
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (!div_stat.busy && !result_held))
    else $error("divider started while busy or quotient not yet delivered");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= win) && (win != '0))
    else $error("fill count exceeds the window");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(pos) < win)
    else $error("write position outside the window");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(result_held))
    else $error("result word raised without a finished division");

endmodule
